FILE: rtl/lcas_pkg.sv
// Shared constants and types for the life automaton step block.
// No dependencies; compiled first.
package lcas_pkg;

  localparam int LCAS_MAX_COLS = 256;
  localparam int LCAS_MAX_ROWS = 1024;

  // register field widths and APB geometry
  localparam int ROW_COUNT_W = 11;
  localparam int COL_COUNT_W = 9;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 4;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [1:0] REG_COL_COUNT   = 2'd1;
  localparam logic [1:0] REG_RULE_SELECT = 2'd2;

  // input item kinds
  localparam logic MODE_CELL  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // rule codes
  localparam logic RULE_STANDARD = 1'b0;
  localparam logic RULE_KEEP     = 1'b1;

  // 3x3 neighborhood around the emitted cell
  typedef struct packed {
    logic nw;
    logic n;
    logic ne;
    logic w;
    logic self;
    logic e;
    logic sw;
    logic s;
    logic se;
  } lcas_nbr_t;

  // which sides of the emitted cell lie inside the grid
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } lcas_border_t;

endpackage

FILE: rtl/lcas_if.sv
// Valid/ready stream interfaces for cell requests and results.
// No dependencies.
interface lcas_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic cell_alive;

  modport source (output valid, output mode, output cell_alive, input ready);
  modport sink   (input valid, input mode, input cell_alive, output ready);
endinterface

interface lcas_out_if;
  logic valid;
  logic ready;
  logic next_alive;
  logic last_cell;

  modport source (output valid, output next_alive, output last_cell, input ready);
  modport sink   (input valid, input next_alive, input last_cell, output ready);
endinterface

FILE: rtl/life_cellular_automaton_step_top.sv
// Life automaton step: one cell request accepted per cycle, back to back.
// A cell's result is registered at the edge that accepts the request m+1 positions later
// (m = columns in use) and is offered from the next cycle; a request that would emit
// waits only while a held result is not taken. Synchronous active-high reset clears the
// delay lines, counters and registers (rows 1, columns 1, standard rule).
// Depends on lcas_pkg, lcas_if, lcas_line, lcas_rule.
module life_cellular_automaton_step_top #(
  parameter int MAX_COLS = lcas_pkg::LCAS_MAX_COLS,
  parameter int MAX_ROWS = lcas_pkg::LCAS_MAX_ROWS
) (
  input  logic                              clk,
  input  logic                              rst,
  lcas_in_if.sink                           cell_in,
  lcas_out_if.source                        result_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lcas_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lcas_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lcas_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 2);
  localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // configuration registers
  logic [lcas_pkg::ROW_COUNT_W-1:0] row_count;
  logic [lcas_pkg::COL_COUNT_W-1:0] col_count;
  logic                             rule_select;

  logic       cfg_wr;
  logic [1:0] cfg_idx;
  logic       restart;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  assign restart = cfg_wr && (cfg_idx == lcas_pkg::REG_ROW_COUNT ||
                              cfg_idx == lcas_pkg::REG_COL_COUNT ||
                              cfg_idx == lcas_pkg::REG_RULE_SELECT);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= lcas_pkg::ROW_COUNT_W'(1);
      col_count   <= lcas_pkg::COL_COUNT_W'(1);
      rule_select <= lcas_pkg::RULE_STANDARD;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lcas_pkg::REG_ROW_COUNT:   row_count   <= pwdata[lcas_pkg::ROW_COUNT_W-1:0];
        lcas_pkg::REG_COL_COUNT:   col_count   <= pwdata[lcas_pkg::COL_COUNT_W-1:0];
        lcas_pkg::REG_RULE_SELECT: rule_select <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lcas_pkg::REG_ROW_COUNT:   prdata = lcas_pkg::APB_DATA_W'(row_count);
      lcas_pkg::REG_COL_COUNT:   prdata = lcas_pkg::APB_DATA_W'(col_count);
      lcas_pkg::REG_RULE_SELECT: prdata = lcas_pkg::APB_DATA_W'(rule_select);
      default:                   prdata = '0;
    endcase
  end

  // sizes in use, clamped to 1..MAX
  logic [RW-1:0] n_eff;
  logic [CW-1:0] m_eff;
  logic [31:0]   rc32;
  logic [31:0]   cc32;

  always_comb begin
    rc32 = 32'(row_count);
    cc32 = 32'(col_count);
    if (rc32 == 32'd0)               n_eff = RW'(1);
    else if (rc32 > 32'(MAX_ROWS))   n_eff = RW'(MAX_ROWS);
    else                             n_eff = RW'(rc32);
    if (cc32 == 32'd0)               m_eff = CW'(1);
    else if (cc32 > 32'(MAX_COLS))   m_eff = CW'(MAX_COLS);
    else                             m_eff = CW'(cc32);
  end

  // input position as row/column, output position as row/column
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic [RW-1:0] out_row;
  logic [CW-1:0] out_col;

  logic accept;
  logic in_grid;
  logic emit;
  logic frame_end;
  logic bit_in;

  assign in_grid   = in_row < n_eff;
  assign emit      = (in_row >= RW'(2)) || (in_row == RW'(1) && in_col != '0);
  assign frame_end = (in_row == RW'(n_eff + RW'(1))) && (in_col == '0);
  assign bit_in    = (cell_in.mode == lcas_pkg::MODE_CELL) && in_grid && cell_in.cell_alive;

  // output register
  logic ov;
  logic o_next;
  logic o_last;

  assign cell_in.ready = !emit || !ov || result_out.ready;
  assign accept        = cell_in.valid && cell_in.ready;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (accept) begin
      if (frame_end) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        if (CW'(in_col + CW'(1)) == m_eff) begin
          in_col <= '0;
          in_row <= RW'(in_row + RW'(1));
        end else begin
          in_col <= CW'(in_col + CW'(1));
        end
        if (emit) begin
          if (CW'(out_col + CW'(1)) >= m_eff) begin
            out_col <= '0;
            out_row <= RW'(out_row + RW'(1));
          end else begin
            out_col <= CW'(out_col + CW'(1));
          end
        end
      end
    end
  end

  // window taps: a short pair on the input and one beside each row line
  logic a0, a1, t1, t2, u1, u2;
  logic l1_tail, l2_tail;
  logic [IW-1:0] entry_idx;

  assign entry_idx = IW'(CW'(MAX_COLS) - m_eff);

  lcas_line #(.MAX_COLS(MAX_COLS)) u_line_near (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .entry_idx (entry_idx),
    .din       (bit_in),
    .tail      (l1_tail)
  );

  lcas_line #(.MAX_COLS(MAX_COLS)) u_line_far (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .entry_idx (entry_idx),
    .din       (l1_tail),
    .tail      (l2_tail)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a0 <= 1'b0;
      a1 <= 1'b0;
      t1 <= 1'b0;
      t2 <= 1'b0;
      u1 <= 1'b0;
      u2 <= 1'b0;
    end else if (accept) begin
      a0 <= bit_in;
      a1 <= a0;
      t1 <= l1_tail;
      t2 <= t1;
      u1 <= l2_tail;
      u2 <= u1;
    end
  end

  lcas_pkg::lcas_nbr_t    nbr;
  lcas_pkg::lcas_border_t border;
  logic                   next_alive;

  always_comb begin
    nbr.nw   = u2;
    nbr.n    = u1;
    nbr.ne   = l2_tail;
    nbr.w    = t2;
    nbr.self = t1;
    nbr.e    = l1_tail;
    nbr.sw   = a1;
    nbr.s    = a0;
    nbr.se   = bit_in;
    border.up    = out_row != '0;
    border.down  = RW'(out_row + RW'(1)) < n_eff;
    border.left  = out_col != '0;
    border.right = CW'(out_col + CW'(1)) < m_eff;
  end

  lcas_rule u_rule (
    .nbr         (nbr),
    .border      (border),
    .rule_select (rule_select),
    .next_alive  (next_alive)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (accept && emit) begin
      ov <= 1'b1;
    end else if (result_out.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      o_next <= next_alive;
      o_last <= frame_end;
    end
  end

  assign result_out.valid      = ov;
  assign result_out.next_alive = o_next;
  assign result_out.last_cell  = o_last;

`ifndef SYNTHESIS
  a_stall_no_emit: assert property (@(posedge clk) disable iff (rst)
    (accept && ov && !result_out.ready) |-> !emit)
    else $error("request accepted over a held result");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |-> emit)
    else $error("frame end without a result");

  a_end_wraps: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> (in_row == '0 && in_col == '0 &&
                               out_row == '0 && out_col == '0))
    else $error("positions not cleared after frame end");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (in_col < m_eff) && (out_col < m_eff))
    else $error("column counter out of range");
`endif

endmodule

FILE: rtl/lcas_cell.sv
// One-bit storage cell of the row delay line.
// Loads either its upstream neighbor or the line input when it is the entry point.
module lcas_cell (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic entry,
  input  logic din_line,
  input  logic din_prev,
  output logic q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b0;
    end else if (en) begin
      q <= entry ? din_line : din_prev;
    end
  end

endmodule

FILE: rtl/lcas_line.sv
// Variable-length row delay line built from a chain of lcas_cell.
// Depends on lcas_pkg and lcas_cell. Length is MAX_COLS - entry_idx cells.
module lcas_line #(
  parameter int MAX_COLS = lcas_pkg::LCAS_MAX_COLS,
  localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [IW-1:0] entry_idx,
  input  logic          din,
  output logic          tail
);

  logic [MAX_COLS-1:0] q;

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_bit
    logic prev;
    if (j == 0) begin : g_first
      assign prev = din;
    end else begin : g_rest
      assign prev = q[j-1];
    end
    lcas_cell u_bit (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .entry    (entry_idx == IW'(j)),
      .din_line (din),
      .din_prev (prev),
      .q        (q[j])
    );
  end

  assign tail = q[MAX_COLS-1];

endmodule

FILE: rtl/lcas_rule.sv
// Neighbor count and birth/survival rule for one emitted cell.
// Depends on lcas_pkg.
module lcas_rule (
  input  lcas_pkg::lcas_nbr_t    nbr,
  input  lcas_pkg::lcas_border_t border,
  input  logic                   rule_select,
  output logic                   next_alive
);

  logic [3:0] cnt;

  always_comb begin
    cnt = 4'(nbr.nw & border.up & border.left)
        + 4'(nbr.n  & border.up)
        + 4'(nbr.ne & border.up & border.right)
        + 4'(nbr.w  & border.left)
        + 4'(nbr.e  & border.right)
        + 4'(nbr.sw & border.down & border.left)
        + 4'(nbr.s  & border.down)
        + 4'(nbr.se & border.down & border.right);
    if (rule_select == lcas_pkg::RULE_STANDARD) begin
      next_alive = nbr.self ? (cnt == 4'd2 || cnt == 4'd3) : (cnt == 4'd3);
    end else begin
      next_alive = nbr.self ? 1'b1 : (cnt == 4'd2);
    end
  end

endmodule
